@@ rtl/tssp_pkg.sv @@
// Shared types and constants for the transport stream section packetizer.
package tssp_pkg;

  localparam int unsigned POS_W      = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CC_W       = 4;
  localparam int unsigned PID_W      = 13;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned FILL_W     = 3;
  localparam int unsigned CNT_W      = 4;

  localparam logic [1:0] ERR_OK  = 2'd0;
  localparam logic [1:0] ERR_LEN = 2'd1;
  localparam logic [1:0] ERR_SEQ = 2'd2;

  localparam logic [7:0] SYNC_BYTE      = 8'h47;
  localparam logic [7:0] UNIT_START_BIT = 8'h40;
  localparam logic [7:0] PAYLOAD_ONLY   = 8'h10;
  localparam logic [7:0] POINTER_BYTE   = 8'h00;
  localparam logic [7:0] FILL_BYTE      = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_PTR,
    ST_DATA,
    ST_PAD
  } state_e;

  typedef enum logic [2:0] {
    K_SEQ_ERR,
    K_LEN_ERR,
    K_NOP,
    K_STUFF,
    K_FIRST,
    K_CONT_HDR,
    K_CONT_DIRECT,
    K_DROP
  } kind_e;

  typedef enum logic [2:0] {
    B_SYNC,
    B_PID_HI,
    B_PID_LO,
    B_CC,
    B_PTR,
    B_DATA_IN,
    B_DATA_Q,
    B_FILL
  } bsel_e;

  typedef struct packed {
    logic       accept;
    logic       append;
    bsel_e      bsel;
    logic       sec_last;
    logic       status;
    logic [1:0] err;
    logic       live_cnt;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  out_free;
    logic  pkt_last;
    logic  sec_in;
    logic  sec_q;
    logic  unit_q;
    logic  stuff_q;
  } stat_t;

endpackage

@@ rtl/tssp_datapath.sv @@
// Datapath: item decode, packet position and counter, word assembly, output register.
module tssp_datapath import tssp_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 188,
  parameter int unsigned MAX_SECTION  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                stream_pid_we_i,
  input  logic [PID_W-1:0]    stream_pid_i,
  input  logic                req_type_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_of_section_i,
  input  logic [LEN_W-1:0]    section_length_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WORD_W-1:0]   out_word_o,
  output logic [CNT_W-1:0]    byte_count_o,
  output logic                packet_end_o,
  output logic                section_end_o,
  output logic [1:0]          error_code_o,
  output logic [CC_W-1:0]     counter_now_o
);

  logic [PID_W-1:0]  pid_q;
  logic [CC_W-1:0]   cc_q;
  logic [POS_W-1:0]  pos_q;
  logic [LEN_W-1:0]  rem_q;
  logic [WORD_W-1:0] asm_q;
  logic [FILL_W-1:0] fill_q;
  logic              drop_q;
  logic [7:0]        byte_q;
  logic              unit_q;
  logic              stuff_q;
  logic [CC_W-1:0]   cnt_item_q;

  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_pend_q;
  logic              out_send_q;
  logic [1:0]        out_err_q;
  logic [CC_W-1:0]   out_cc_q;

  logic              pending;
  logic              len_bad;
  kind_e             kind;
  logic              ends_in;
  logic [CC_W-1:0]   cnt_in;
  logic [LEN_W-1:0]  rem_dec;
  logic [7:0]        app_byte;
  logic [POS_W-1:0]  pos_n;
  logic              pkt_last;
  logic [WORD_W-1:0] asm_n;
  logic [FILL_W:0]   fill_n;
  logic              word_done;
  logic [6:0]        shamt;
  logic [WORD_W-1:0] word_aligned;
  logic              out_free;

  assign pending = (rem_q != '0);
  assign len_bad = (section_length_i == '0) || (section_length_i > LEN_W'(MAX_SECTION));
  assign rem_dec = rem_q - LEN_W'(1);

  always_comb begin
    kind = K_NOP;
    if (req_type_i) begin
      if (pending)           kind = K_SEQ_ERR;
      else if (cc_q != '0)   kind = K_STUFF;
      else                   kind = K_NOP;
    end else if (first_of_section_i) begin
      if (pending)           kind = K_SEQ_ERR;
      else if (len_bad)      kind = K_LEN_ERR;
      else                   kind = K_FIRST;
    end else begin
      if (!pending)          kind = K_SEQ_ERR;
      else if (drop_q)       kind = K_DROP;
      else if (pos_q == '0)  kind = K_CONT_HDR;
      else                   kind = K_CONT_DIRECT;
    end
  end

  // An item ends at most one packet, and that packet end is its last byte.
  always_comb begin
    case (kind)
      K_STUFF:       ends_in = 1'b1;
      K_FIRST:       ends_in = (section_length_i == LEN_W'(1));
      K_CONT_HDR:    ends_in = (rem_q == LEN_W'(1));
      K_CONT_DIRECT: ends_in = (rem_q == LEN_W'(1)) || (pos_n >= POS_W'(PACKET_BYTES));
      default:       ends_in = 1'b0;
    endcase
  end
  assign cnt_in = cc_q + CC_W'(ends_in);

  always_comb begin
    case (cmd_i.bsel)
      B_SYNC:    app_byte = SYNC_BYTE;
      B_PID_HI:  app_byte = (unit_q ? UNIT_START_BIT : 8'h00) | {3'b000, pid_q[12:8]};
      B_PID_LO:  app_byte = pid_q[7:0];
      B_CC:      app_byte = PAYLOAD_ONLY | {4'h0, cc_q};
      B_PTR:     app_byte = POINTER_BYTE;
      B_DATA_IN: app_byte = data_byte_i;
      B_DATA_Q:  app_byte = byte_q;
      B_FILL:    app_byte = FILL_BYTE;
      default:   app_byte = FILL_BYTE;
    endcase
  end

  assign pos_n        = pos_q + POS_W'(1);
  assign pkt_last     = (pos_n >= POS_W'(PACKET_BYTES));
  assign asm_n        = {asm_q[WORD_W-9:0], app_byte};
  assign fill_n       = {1'b0, fill_q} + (FILL_W+1)'(1);
  assign word_done    = pkt_last || (fill_n == (FILL_W+1)'(WORD_BYTES));
  assign shamt        = {(4'(WORD_BYTES) - fill_n), 3'b000};
  assign word_aligned = asm_n << shamt;
  assign out_free     = !out_valid_q || !out_stall_i;

  assign stat_o.kind     = kind;
  assign stat_o.out_free = out_free;
  assign stat_o.pkt_last = pkt_last;
  assign stat_o.sec_in   = (rem_q == LEN_W'(1));
  assign stat_o.sec_q    = (rem_q == '0) && !stuff_q;
  assign stat_o.unit_q   = unit_q;
  assign stat_o.stuff_q  = stuff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q  <= '0;
      cc_q   <= '0;
      pos_q  <= '0;
      rem_q  <= '0;
      asm_q  <= '0;
      fill_q <= '0;
      drop_q <= 1'b0;
    end else begin
      if (stream_pid_we_i) begin
        pid_q <= stream_pid_i;
      end
      if (cmd_i.append) begin
        pos_q  <= pkt_last ? '0 : pos_n;
        asm_q  <= word_done ? '0 : asm_n;
        fill_q <= word_done ? '0 : fill_n[FILL_W-1:0];
        if (pkt_last) begin
          cc_q <= cc_q + CC_W'(1);
        end
      end
      if (cmd_i.accept) begin
        case (kind)
          K_LEN_ERR: begin
            // A zero length opens nothing; a long one swallows the rest of its bytes.
            rem_q  <= (section_length_i == '0) ? '0 : section_length_i - LEN_W'(1);
            drop_q <= (section_length_i > LEN_W'(1));
          end
          K_FIRST: begin
            rem_q  <= section_length_i - LEN_W'(1);
            drop_q <= 1'b0;
          end
          K_CONT_HDR, K_CONT_DIRECT: begin
            rem_q <= rem_dec;
          end
          K_DROP: begin
            rem_q <= rem_dec;
            if (rem_dec == '0) begin
              drop_q <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q     <= data_byte_i;
      unit_q     <= (kind == K_FIRST);
      stuff_q    <= (kind == K_STUFF);
      cnt_item_q <= cnt_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.status || (cmd_i.append && word_done)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.status) begin
      out_word_q <= '0;
      out_cnt_q  <= '0;
      out_pend_q <= 1'b0;
      out_send_q <= 1'b0;
      out_err_q  <= cmd_i.err;
      out_cc_q   <= cc_q;
    end else if (cmd_i.append && word_done) begin
      out_word_q <= word_aligned;
      out_cnt_q  <= fill_n;
      out_pend_q <= pkt_last;
      out_send_q <= pkt_last && cmd_i.sec_last;
      out_err_q  <= ERR_OK;
      out_cc_q   <= cmd_i.live_cnt ? cnt_in : cnt_item_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_word_o    = out_word_q;
  assign byte_count_o  = out_cnt_q;
  assign packet_end_o  = out_pend_q;
  assign section_end_o = out_send_q;
  assign error_code_o  = out_err_q;
  assign counter_now_o = out_cc_q;

  // A packet boundary always flushes the partial word.
  a_flush_at_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (fill_q == '0)) else $error("partial word left at packet start");

  a_drop_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == '0) |-> !drop_q) else $error("drop flag set with no section pending");

  a_pos_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(PACKET_BYTES)) else $error("packet position past packet size");

endmodule

@@ rtl/tssp_ctrl.sv @@
// Controller state machine: sequences header, pointer, data and fill bytes.
module tssp_ctrl import tssp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && stat_i.out_free) begin
          case (stat_i.kind)
            K_STUFF, K_FIRST, K_CONT_HDR: state_d = ST_HDR;
            K_CONT_DIRECT: begin
              if (stat_i.sec_in && !stat_i.pkt_last) state_d = ST_PAD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HDR: begin
        if (stat_i.out_free) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            if (stat_i.unit_q)       state_d = ST_PTR;
            else if (stat_i.stuff_q) state_d = ST_PAD;
            else                     state_d = ST_DATA;
          end
        end
      end
      ST_PTR: begin
        if (stat_i.out_free) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (stat_i.out_free) begin
          state_d = (stat_i.sec_q && !stat_i.pkt_last) ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (stat_i.out_free && stat_i.pkt_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.bsel     = B_SYNC;
    cmd_o.err      = ERR_OK;
    in_stall_o     = !((state_q == ST_IDLE) && stat_i.out_free);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.accept   = 1'b1;
          cmd_o.live_cnt = 1'b1;
          case (stat_i.kind)
            K_SEQ_ERR: begin
              cmd_o.status = 1'b1;
              cmd_o.err    = ERR_SEQ;
            end
            K_LEN_ERR: begin
              cmd_o.status = 1'b1;
              cmd_o.err    = ERR_LEN;
            end
            K_CONT_DIRECT: begin
              cmd_o.append   = 1'b1;
              cmd_o.bsel     = B_DATA_IN;
              cmd_o.sec_last = stat_i.sec_in;
            end
            default: begin
            end
          endcase
        end
      end
      ST_HDR: begin
        cmd_o.append = stat_i.out_free;
        case (idx_q)
          2'd0:    cmd_o.bsel = B_SYNC;
          2'd1:    cmd_o.bsel = B_PID_HI;
          2'd2:    cmd_o.bsel = B_PID_LO;
          default: cmd_o.bsel = B_CC;
        endcase
      end
      ST_PTR: begin
        cmd_o.append = stat_i.out_free;
        cmd_o.bsel   = B_PTR;
      end
      ST_DATA: begin
        cmd_o.append   = stat_i.out_free;
        cmd_o.bsel     = B_DATA_Q;
        cmd_o.sec_last = stat_i.sec_q;
      end
      ST_PAD: begin
        cmd_o.append   = stat_i.out_free;
        cmd_o.bsel     = B_FILL;
        cmd_o.sec_last = stat_i.sec_q;
      end
      default: begin
      end
    endcase
  end

  a_idx_only_in_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_HDR) |-> (idx_q == '0)) else $error("header index left nonzero");

  a_pad_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD && cmd_o.append && stat_i.pkt_last) |=> (state_q == ST_IDLE))
    else $error("fill did not stop at packet end");

  a_stall_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("input taken while busy");

endmodule

@@ rtl/ts_section_packetizer_core.sv @@
// Top level of the transport stream section packetizer.
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  --------------------------------------
//  input     in         in_valid_i / in_stall_o     req_type, data_byte, first_of_section,
//                                                   section_length
//  output    out        out_valid_o / out_stall_i   out_word, byte_count, packet_end,
//                                                   section_end, error_code, counter_now
//  config    in         stream_pid_we_i             stream_pid (13 bits)
//
// A section byte in the middle of a packet is taken straight from the idle state. A byte
// that opens a packet is preceded by the four header bytes, the first byte of a section
// by the header and pointer byte, and a byte that closes a section is followed by fill
// bytes up to the packet end. Stuffing sends a header and fill up to the packet end. The
// word assembler places one packet byte per cycle while the output register is free.
// Reset is asynchronous and active low; it clears the counter, packet position, pending
// section state and the output valid flag. Each cycle of output stall holds the byte
// sequencer whenever a finished word is waiting, and no new transaction is taken then.
module ts_section_packetizer_core import tssp_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 188,
  parameter int unsigned MAX_SECTION  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                stream_pid_we_i,
  input  logic [PID_W-1:0]    stream_pid_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_of_section_i,
  input  logic [LEN_W-1:0]    section_length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WORD_W-1:0]   out_word_o,
  output logic [CNT_W-1:0]    byte_count_o,
  output logic                packet_end_o,
  output logic                section_end_o,
  output logic [1:0]          error_code_o,
  output logic [CC_W-1:0]     counter_now_o
);

  cmd_t  cmd;
  stat_t stat;

  // The controller owns sequencing; the datapath decodes each transaction and reports
  // its kind, and it also holds the finished-word register that decouples the sides.
  tssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tssp_datapath #(
    .PACKET_BYTES (PACKET_BYTES),
    .MAX_SECTION  (MAX_SECTION)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .stream_pid_we_i    (stream_pid_we_i),
    .stream_pid_i       (stream_pid_i),
    .req_type_i         (req_type_i),
    .data_byte_i        (data_byte_i),
    .first_of_section_i (first_of_section_i),
    .section_length_i   (section_length_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_word_o         (out_word_o),
    .byte_count_o       (byte_count_o),
    .packet_end_o       (packet_end_o),
    .section_end_o      (section_end_o),
    .error_code_o       (error_code_o),
    .counter_now_o      (counter_now_o)
  );

endmodule

@@ verif/tb_ts_section_packetizer_core.sv @@
// Self-checking testbench for the transport stream section packetizer core.
`timescale 1ns / 100ps

module tb_ts_section_packetizer_core;
  import tssp_pkg::*;

  localparam int unsigned PACKET_BYTES   = 188;
  localparam int unsigned MAX_SECTION    = 4096;
  // Stuffing is the slowest transaction that can finish without a trailing word on the bus,
  // so a wait sized from the packet length covers anything in flight before a register write.
  localparam int unsigned SETTLE_CYCLES  = 2 * PACKET_BYTES;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 30;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_STUFF = 1'b1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // One input transaction as it sits on the input channel.
  typedef struct packed {
    logic             stuff;
    logic [7:0]       data;
    logic             first;
    logic [LEN_W-1:0] len;
  } ts_item_t;

  // One output transaction: a packet word or a status-only word.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic              pkt_end;
    logic              sec_end;
    logic [1:0]        err;
    logic [CC_W-1:0]   cc;
  } ts_word_t;

  logic              clk_i;
  logic              rst_ni             = 1'b0;
  logic              stream_pid_we_i    = 1'b0;
  logic [PID_W-1:0]  stream_pid_i       = '0;
  logic              in_valid_i         = 1'b0;
  logic              in_stall_o;
  logic              req_type_i         = REQ_BYTE;
  logic [7:0]        data_byte_i        = '0;
  logic              first_of_section_i = 1'b0;
  logic [LEN_W-1:0]  section_length_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i        = 1'b0;
  logic [WORD_W-1:0] out_word_o;
  logic [CNT_W-1:0]  byte_count_o;
  logic              packet_end_o;
  logic              section_end_o;
  logic [1:0]        error_code_o;
  logic [CC_W-1:0]   counter_now_o;

  ts_section_packetizer_core #(
    .PACKET_BYTES(PACKET_BYTES),
    .MAX_SECTION (MAX_SECTION)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .stream_pid_we_i   (stream_pid_we_i),
    .stream_pid_i      (stream_pid_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .data_byte_i       (data_byte_i),
    .first_of_section_i(first_of_section_i),
    .section_length_i  (section_length_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_word_o        (out_word_o),
    .byte_count_o      (byte_count_o),
    .packet_end_o      (packet_end_o),
    .section_end_o     (section_end_o),
    .error_code_o      (error_code_o),
    .counter_now_o     (counter_now_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Packet predictor. It mirrors the block's state and, for every accepted input
  // transaction, appends the words that transaction produces to expected_words.
  // ---------------------------------------------------------------------------
  logic [PID_W-1:0]  pid_now  = '0;
  logic [CC_W-1:0]   cc       = '0;
  logic [POS_W-1:0]  pkt_pos  = '0;
  logic [LEN_W-1:0]  sec_left = '0;
  logic [WORD_W-1:0] asm_word = '0;
  logic [FILL_W-1:0] asm_fill = '0;
  logic              sec_drop = 1'b0;

  ts_word_t expected_words[$];
  ts_word_t item_words[$];

  // Places one byte into the current packet. A word goes out when eight bytes are
  // collected or when the byte closes the packet, in which case the word is left
  // aligned and its unused low bytes stay zero.
  function automatic void pkt_place_byte(logic [7:0] b, logic sec_last);
    logic [3:0] fill;
    logic       last;
    ts_word_t   r;
    pkt_pos  = pkt_pos + 1'b1;
    last     = (pkt_pos >= PACKET_BYTES);
    asm_word = {asm_word[WORD_W-9:0], b};
    fill     = {1'b0, asm_fill} + 4'd1;
    if (fill == 4'd8 || last) begin
      r         = '0;
      r.word    = asm_word << (8 * (8 - fill));
      r.count   = fill;
      r.pkt_end = last;
      r.sec_end = last & sec_last;
      r.err     = ERR_OK;
      item_words.push_back(r);
      asm_word  = '0;
      fill      = '0;
    end
    asm_fill = fill[FILL_W-1:0];
    if (last) begin
      pkt_pos = '0;
      cc      = cc + 1'b1;
    end
  endfunction

  function automatic void pkt_header(logic unit_start);
    pkt_place_byte(SYNC_BYTE, 1'b0);
    pkt_place_byte((unit_start ? UNIT_START_BIT : 8'h00) | {3'b000, pid_now[12:8]}, 1'b0);
    pkt_place_byte(pid_now[7:0], 1'b0);
    pkt_place_byte(PAYLOAD_ONLY | {4'h0, cc}, 1'b0);
  endfunction

  function automatic void pkt_pad(logic sec_last);
    while (pkt_pos != 0) pkt_place_byte(FILL_BYTE, sec_last);
  endfunction

  function automatic void pkt_status(logic [1:0] code);
    ts_word_t r;
    r     = '0;
    r.err = code;
    item_words.push_back(r);
  endfunction

  function automatic void packetize_item(ts_item_t it);
    logic pending;
    pending = (sec_left != 0);
    item_words.delete();
    if (it.stuff == REQ_STUFF) begin
      if (pending) begin
        pkt_status(ERR_SEQ);
      end else if (cc != 0) begin
        pkt_header(1'b0);
        pkt_pad(1'b0);
      end
    end else if (it.first) begin
      if (pending) begin
        pkt_status(ERR_SEQ);
      end else if (it.len == 0 || it.len > MAX_SECTION) begin
        // The rest of a rejected section is swallowed without a word.
        pkt_status(ERR_LEN);
        sec_left = (it.len == 0) ? '0 : it.len - 1'b1;
        sec_drop = (sec_left != 0);
      end else begin
        sec_drop = 1'b0;
        sec_left = it.len - 1'b1;
        pkt_header(1'b1);
        pkt_place_byte(POINTER_BYTE, 1'b0);
        pkt_place_byte(it.data, sec_left == 0);
        if (sec_left == 0) pkt_pad(1'b1);
      end
    end else begin
      if (!pending) begin
        pkt_status(ERR_SEQ);
      end else if (sec_drop) begin
        sec_left = sec_left - 1'b1;
        if (sec_left == 0) sec_drop = 1'b0;
      end else begin
        sec_left = sec_left - 1'b1;
        if (pkt_pos == 0) pkt_header(1'b0);
        pkt_place_byte(it.data, sec_left == 0);
        if (sec_left == 0) pkt_pad(1'b1);
      end
    end
    // The counter reported on every word is the one after the whole transaction.
    foreach (item_words[k]) begin
      item_words[k].cc = cc;
      expected_words.push_back(item_words[k]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator keeps its own view of whether a section is
  // still open, so that phases always end with every section closed and so that
  // swallowed bytes of rejected sections are not counted as stimulus.
  // ---------------------------------------------------------------------------
  ts_item_t    pending_items[$];
  logic [LEN_W-1:0] gen_left    = '0;
  logic        gen_drop    = 1'b0;
  int unsigned gen_counted = 0;

  function automatic void queue_item(logic stuff, logic [7:0] data, logic first,
                                     logic [LEN_W-1:0] len);
    ts_item_t it;
    if (!(stuff == REQ_BYTE && !first && gen_drop)) gen_counted++;
    if (stuff == REQ_BYTE) begin
      if (first) begin
        if (gen_left == 0) begin
          gen_drop = (len == 0 || len > MAX_SECTION) && len > 1;
          gen_left = (len == 0) ? '0 : len - 1'b1;
        end
      end else if (gen_left != 0) begin
        gen_left = gen_left - 1'b1;
        if (gen_left == 0) gen_drop = 1'b0;
      end
    end
    it.stuff = stuff;
    it.data  = data;
    it.first = first;
    it.len   = len;
    pending_items.push_back(it);
  endfunction

  function automatic void close_section();
    while (gen_left != 0)
      queue_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, LEN_W'($urandom));
  endfunction

  // A section with random content. With noisy set, a stray first byte or a stuffing
  // request lands somewhere inside it and must be refused without disturbing it.
  function automatic void queue_section(int unsigned len, bit noisy);
    int unsigned noise_at;
    noise_at = (noisy && len > 1) ? $urandom_range(1, len - 1) : 0;
    queue_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b1, LEN_W'(len));
    for (int unsigned i = 1; i < len; i++) begin
      if (i == noise_at)
        queue_item($urandom_range(0, 1) ? REQ_STUFF : REQ_BYTE, 8'($urandom_range(0, 255)),
                   1'b1, LEN_W'($urandom));
      queue_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, LEN_W'($urandom));
    end
  endfunction

  // Any transaction at all. A first byte that would open a section gets a short
  // length so that a rejected one does not swallow tens of thousands of bytes.
  function automatic void queue_noise();
    logic stuff;
    logic first;
    stuff = 1'($urandom_range(0, 1));
    first = 1'($urandom_range(0, 1));
    if (stuff == REQ_BYTE && first && gen_left == 0)
      queue_item(stuff, 8'($urandom_range(0, 255)), first, LEN_W'($urandom_range(0, 64)));
    else
      queue_item(stuff, 8'($urandom_range(0, 255)), first, LEN_W'($urandom));
  endfunction

  // Mostly short sections, now and then one that fills a good part of a packet.
  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return $urandom_range(1, 12);
    return $urandom_range(13, 40);
  endfunction

  // Mostly well-formed sections with random content; the rest is stuffing, stray
  // transactions, refused lengths and sections broken by out-of-sequence requests.
  function automatic void queue_random_phase(int unsigned target);
    int unsigned stop;
    int unsigned sel;
    stop = gen_counted + target;
    while (gen_counted < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 60)      queue_section(pick_length(), 1'b0);
      else if (sel < 72) queue_section(pick_length(), 1'b1);
      else if (sel < 84) queue_item(REQ_STUFF, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), LEN_W'($urandom));
      else               queue_noise();
      close_section();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. Transactions leave pending_items in bursts of random length with
  // random gaps between them; a stalled transaction is held unchanged.
  // ---------------------------------------------------------------------------
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned items_taken = 0;

  always @(posedge clk_i) begin : in_driver
    ts_item_t took;
    ts_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        took.stuff = req_type_i;
        took.data  = data_byte_i;
        took.first = first_of_section_i;
        took.len   = section_length_i;
        packetize_item(took);
        items_taken <= items_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_valid_i         <= 1'b1;
          req_type_i         <= nxt.stuff;
          data_byte_i        <= nxt.data;
          first_of_section_i <= nxt.first;
          section_length_i   <= nxt.len;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // A third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor. Every accepted word is checked against the oldest expected
  // word. The stall pattern switches at random among no stall, light and heavy
  // random stalling, and a fixed periodic pattern.
  // ---------------------------------------------------------------------------
  int unsigned fail_count    = 0;
  int unsigned words_checked = 0;
  stall_mode_e stall_mode    = STALL_NONE;
  int unsigned stall_left    = 0;
  int unsigned stall_tick    = 0;

  always @(posedge clk_i) begin : out_monitor
    ts_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word %h cnt %0d pend %b send %b err %0d cc %0d",
                     out_word_o, byte_count_o, packet_end_o, section_end_o,
                     error_code_o, counter_now_o);
        end else begin
          want = expected_words.pop_front();
          words_checked <= words_checked + 1;
          if (out_word_o !== want.word || byte_count_o !== want.count ||
              packet_end_o !== want.pkt_end || section_end_o !== want.sec_end ||
              error_code_o !== want.err || counter_now_o !== want.cc) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h cnt %0d pend %b send %b err %0d cc %0d, %s",
                       want.word, want.count, want.pkt_end, want.sec_end, want.err,
                       want.cc, $sformatf("got %h cnt %0d pend %b send %b err %0d cc %0d",
                       out_word_o, byte_count_o, packet_end_o, section_end_o,
                       error_code_o, counter_now_o));
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(32, 256);
      end else begin
        stall_left--;
      end
      stall_tick++;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ((stall_tick % 7) >= 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog. It counts cycles in which neither an input transaction nor a checked
  // output transaction happened; it sees each change of the counters it watches in
  // the cycle after it is made, which only delays its count.
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;
  int unsigned seen_items  = 0;
  int unsigned seen_words  = 0;

  always @(posedge clk_i) begin
    if (items_taken != seen_items || words_checked != seen_words) begin
      idle_cycles <= 0;
      seen_items  <= items_taken;
      seen_words  <= words_checked;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_ts_section_packetizer_core: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset, a directed phase at the reset PID, then random phases, each
  // behind a PID write made while the block is idle.
  // ---------------------------------------------------------------------------
  task automatic drain_and_settle();
    while (pending_items.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_pid(logic [PID_W-1:0] pid);
    @(posedge clk_i);
    stream_pid_i    <= pid;
    stream_pid_we_i <= 1'b1;
    @(posedge clk_i);
    stream_pid_we_i <= 1'b0;
    pid_now = pid;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Stuffing right after reset finds the counter at zero and must do nothing.
    queue_item(REQ_STUFF, 8'hFF, 1'b1, 16'hFFFF);
    // A continuation byte with no section open is out of sequence.
    queue_item(REQ_BYTE, 8'hFF, 1'b0, 16'hFFFF);
    // A zero length is refused and swallows nothing.
    queue_item(REQ_BYTE, 8'h00, 1'b1, 16'h0000);
    // A one-byte section fills a whole packet with its tail.
    queue_item(REQ_BYTE, 8'h00, 1'b1, 16'd1);
    // Now the counter is nonzero, so stuffing emits one padding packet.
    queue_item(REQ_STUFF, 8'h00, 1'b0, 16'h0000);
    // A three-byte section interrupted by a first byte and by a stuffing request.
    queue_item(REQ_BYTE, 8'hA5, 1'b1, 16'd3);
    queue_item(REQ_BYTE, 8'h5A, 1'b1, 16'h0000);
    queue_item(REQ_STUFF, 8'hFF, 1'b1, 16'hFFFF);
    queue_item(REQ_BYTE, 8'hFF, 1'b0, 16'hFFFF);
    queue_item(REQ_BYTE, 8'h00, 1'b0, 16'h0000);
    // One byte more than the first packet holds, so the last byte opens a second
    // packet behind a fresh header.
    queue_section(PACKET_BYTES - 4, 1'b0);
    // Stuffing behind it emits a padding packet.
    queue_item(REQ_STUFF, 8'h81, 1'b1, 16'h8001);
    drain_and_settle();

    write_pid(13'h1FFF);
    queue_random_phase(PHASE_ITEMS);
    drain_and_settle();

    write_pid(13'h0000);
    queue_random_phase(PHASE_ITEMS);
    drain_and_settle();

    write_pid(PID_W'($urandom));
    queue_random_phase(PHASE_ITEMS);
    drain_and_settle();

    write_pid(13'h0AAA);
    queue_random_phase(PHASE_ITEMS);
    drain_and_settle();

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("tb_ts_section_packetizer_core: PASS");
    end else begin
      $display("tb_ts_section_packetizer_core: FAIL");
    end
    $finish;
  end

endmodule
